// ===== rtl/core/hhp_pkg.sv =====
// Shared types and constants for the heading-hold PID loop.
// Used by hhp_mac, hhp_div, heading_hold_pid_loop, hhp_checker and testbench; no dependencies.
`default_nettype none
package hhp_pkg;

  // Default command limit.
  localparam int CMD_MAX_DEF = 9600;

  // Register map indexes (byte address = 4 * index).
  localparam int          REG_IDX_W     = 3;
  localparam logic [2:0]  REG_PROP_GAIN = 3'd0;
  localparam logic [2:0]  REG_DERIV_GAIN = 3'd1;
  localparam logic [2:0]  REG_INTEG_GAIN = 3'd2;
  localparam logic [2:0]  REG_YAW_TRIM  = 3'd3;
  localparam logic [2:0]  REG_HDG_STEP  = 3'd4;

  // Register reset values.
  localparam logic signed [31:0] PROP_GAIN_RST  = -32'sd804248;
  localparam logic signed [31:0] DERIV_GAIN_RST = -32'sd614400;
  localparam logic signed [31:0] INTEG_GAIN_RST = -32'sd322;
  localparam logic signed [14:0] YAW_TRIM_RST   = 15'sd350;
  localparam logic [14:0]        HDG_STEP_RST   = 15'd410;

  // Datapath widths.
  localparam int ACC_W    = 64;  // exact PID sum
  localparam int OP_W     = 32;  // multiplicand / multiplier operand
  localparam int BIT_IDX_W = 5;  // multiplier bit index
  localparam int FRAC_W   = 24;  // gain fraction bits
  localparam int STEP_MAG_W = 29; // |yaw_stick * heading_step|

  // Serial MAC control.
  typedef struct packed {
    logic                  start;     // load operands and run
    logic                  clear;     // zero the accumulator on start
    logic [BIT_IDX_W-1:0]  last_idx;  // index of the multiplier sign bit
  } mac_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/hhp_mac.sv =====
// Bit-serial signed multiply-accumulate: acc -= mcand * mplier, one
// multiplier bit per cycle. Depends on hhp_pkg.
`default_nettype none
module hhp_mac (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  hhp_pkg::mac_cmd_t              cmd,
  input  wire  logic signed [hhp_pkg::OP_W-1:0] mcand,
  input  wire  logic [hhp_pkg::OP_W-1:0]       mplier,
  output logic                                 done,
  output logic [hhp_pkg::ACC_W-1:0]            acc
);

  logic                              busy;
  logic [hhp_pkg::BIT_IDX_W-1:0]     cnt;
  logic [hhp_pkg::BIT_IDX_W-1:0]     last_idx;
  logic [hhp_pkg::ACC_W-1:0]         mc;
  logic [hhp_pkg::OP_W-1:0]          mp;
  logic                              at_sign;

  assign at_sign = (cnt == last_idx);

  // Control: run from start until the sign bit has been consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (at_sign) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: negated two's complement shift-add, sign bit weighs negative
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mc       <= hhp_pkg::ACC_W'(mcand);
      mp       <= mplier;
      last_idx <= cmd.last_idx;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mp[0]) begin
        if (at_sign) begin
          acc <= acc + mc;
        end else begin
          acc <= acc - mc;
        end
      end
      mc <= {mc[hhp_pkg::ACC_W-2:0], 1'b0};
      mp <= {1'b0, mp[hhp_pkg::OP_W-1:1]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/hhp_div.sv =====
// Restoring divider by a constant, one quotient bit per cycle.
// Depends on hhp_pkg for the dividend width.
`default_nettype none
module hhp_div #(
  parameter int DIVISOR = hhp_pkg::CMD_MAX_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire  logic [hhp_pkg::STEP_MAG_W-1:0] dividend,
  output logic                                done,
  output logic [hhp_pkg::STEP_MAG_W-1:0]      quotient
);

  localparam int DW  = hhp_pkg::STEP_MAG_W;
  localparam int RW  = $clog2(DIVISOR);
  localparam int CW  = $clog2(DW);
  localparam logic [RW:0] DIV_C = (RW+1)'(DIVISOR);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = (trial >= DIV_C);

  // Control: DW steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out MSB first, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= RW'(trial - DIV_C);
      end else begin
        rem <= trial[RW-1:0];
      end
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/heading_hold_pid_loop.sv =====
// Heading-hold PID loop, top level: stream ports, APB registers, sequencer.
// Depends on hhp_pkg, hhp_mac and hhp_div.
// Path: in flight an item runs through the bit-serial MAC (16 + 16 + 16 + 32 bits)
//   and the 29-step divider; on ground it goes straight to the output state.
// Throughput: one item at a time; the next input is taken once the result is
//   registered, while that result may still wait on the output.
// Reset: synchronous; clears setpoint, integrator, registers to defaults, no pending output.
`default_nettype none
module heading_hold_pid_loop #(
  parameter int CMD_MAX = hhp_pkg::CMD_MAX_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // Input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] heading, [31:16] yaw_rate, [46:32] yaw_stick, [62:47] roll_setpoint,
  // [78:63] pitch_setpoint, [94:79] throttle_stick, [95] zero
  input  wire  [95:0] s_axis_tdata,
  // [0] in_flight
  input  wire         s_axis_tuser,
  // Output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [14:0] yaw_cmd, [29:15] roll_cmd, [44:30] pitch_cmd, [59:45] throttle_cmd,
  // [63:60] zero
  output logic [63:0] m_axis_tdata,
  // Configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic signed [40:0] CMAX41 = 41'(CMD_MAX);
  localparam logic signed [16:0] CMAX17 = 17'(CMD_MAX);
  localparam logic [hhp_pkg::ACC_W-1:0] RND_BIAS =
    hhp_pkg::ACC_W'((64'd1 << hhp_pkg::FRAC_W) - 64'd1);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_STEP_MUL = 9'b000000010,
    ST_STEP_DIV = 9'b000000100,
    ST_ERR      = 9'b000001000,
    ST_MUL_P    = 9'b000010000,
    ST_MUL_D    = 9'b000100000,
    ST_MUL_I    = 9'b001000000,
    ST_ROUND    = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic signed [31:0] prop_gain, deriv_gain, integ_gain;
  logic signed [14:0] yaw_trim;
  logic [14:0]        heading_step;

  // Loop state
  logic [15:0]        heading_target;
  logic signed [31:0] error_sum;

  // Latched item
  logic               flying;
  logic signed [15:0] heading, yaw_rate, roll_sp, pitch_sp, thr_sp;

  logic               step_neg;
  logic signed [39:0] acc_q;

  // Units
  hhp_pkg::mac_cmd_t             mac_cmd;
  logic signed [31:0]            mac_mcand;
  logic [31:0]                   mac_mplier;
  logic                          mac_done;
  logic [hhp_pkg::ACC_W-1:0]     mac_acc;
  logic                          div_start;
  logic [hhp_pkg::STEP_MAG_W-1:0] div_dividend;
  logic                          div_done;
  logic [hhp_pkg::STEP_MAG_W-1:0] div_quot;

  hhp_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mac_cmd),
    .mcand  (mac_mcand),
    .mplier (mac_mplier),
    .done   (mac_done),
    .acc    (mac_acc)
  );

  hhp_div #(.DIVISOR(CMD_MAX)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quot)
  );

  logic in_acc;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // APB: always ready, write on access phase
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= hhp_pkg::PROP_GAIN_RST;
      deriv_gain   <= hhp_pkg::DERIV_GAIN_RST;
      integ_gain   <= hhp_pkg::INTEG_GAIN_RST;
      yaw_trim     <= hhp_pkg::YAW_TRIM_RST;
      heading_step <= hhp_pkg::HDG_STEP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hhp_pkg::REG_PROP_GAIN:  prop_gain    <= pwdata;
        hhp_pkg::REG_DERIV_GAIN: deriv_gain   <= pwdata;
        hhp_pkg::REG_INTEG_GAIN: integ_gain   <= pwdata;
        hhp_pkg::REG_YAW_TRIM:   yaw_trim     <= pwdata[14:0];
        hhp_pkg::REG_HDG_STEP:   heading_step <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hhp_pkg::REG_PROP_GAIN:  prdata = prop_gain;
      hhp_pkg::REG_DERIV_GAIN: prdata = deriv_gain;
      hhp_pkg::REG_INTEG_GAIN: prdata = integ_gain;
      hhp_pkg::REG_YAW_TRIM:   prdata = 32'(yaw_trim);
      hhp_pkg::REG_HDG_STEP:   prdata = {17'd0, heading_step};
      default:                 prdata = '0;
    endcase
  end

  // Heading error and saturated integrator input
  logic signed [15:0] err;
  logic signed [32:0] sum33;
  logic signed [31:0] sum_sat;
  assign err   = heading - heading_target;
  assign sum33 = 33'(error_sum) + 33'(err);
  always_comb begin
    if (sum33[32] != sum33[31]) begin
      sum_sat = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum33[31:0];
    end
  end

  // Magnitude of -(stick * step), which fits 30 signed bits
  logic [29:0] step_prod;
  assign step_prod    = mac_acc[29:0];
  assign div_dividend = mac_acc[hhp_pkg::ACC_W-1] ? 29'(-step_prod) : step_prod[28:0];

  logic [15:0] delta;
  assign delta = step_neg ? (16'd0 - div_quot[15:0]) : div_quot[15:0];

  // Sequencer: next state and unit starts
  logic out_free;
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  always_comb begin
    state_next       = state;
    mac_cmd.start    = 1'b0;
    mac_cmd.clear    = 1'b0;
    mac_cmd.last_idx = hhp_pkg::BIT_IDX_W'(15);
    mac_mcand        = prop_gain;
    mac_mplier       = 32'(err);
    div_start        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            mac_cmd.start = 1'b1;
            mac_cmd.clear = 1'b1;
            mac_mcand     = 32'(signed'(s_axis_tdata[46:32]));
            mac_mplier    = {17'd0, heading_step};
            state_next    = ST_STEP_MUL;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_STEP_MUL: begin
        if (mac_done) begin
          div_start  = 1'b1;
          state_next = ST_STEP_DIV;
        end
      end
      ST_STEP_DIV: begin
        if (div_done) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clear = 1'b1;
        state_next    = ST_MUL_P;
      end
      ST_MUL_P: begin
        mac_mcand  = deriv_gain;
        mac_mplier = 32'(yaw_rate);
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          state_next    = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        mac_mcand        = integ_gain;
        mac_mplier       = error_sum;
        mac_cmd.last_idx = hhp_pkg::BIT_IDX_W'(31);
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          state_next    = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        if (mac_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_target <= '0;
      error_sum      <= '0;
    end else if (in_acc && !s_axis_tuser) begin
      heading_target <= s_axis_tdata[15:0];
      error_sum      <= '0;
    end else if (state == ST_STEP_DIV && div_done) begin
      heading_target <= heading_target + delta;
    end else if (state == ST_ERR) begin
      error_sum <= sum_sat;
    end
  end

  // Latch the item and intermediate results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      flying    <= s_axis_tuser;
      heading   <= s_axis_tdata[15:0];
      yaw_rate  <= s_axis_tdata[31:16];
      roll_sp   <= s_axis_tdata[62:47];
      pitch_sp  <= s_axis_tdata[78:63];
      thr_sp    <= s_axis_tdata[94:79];
    end
    if (state == ST_STEP_MUL && mac_done) begin
      step_neg <= mac_acc[hhp_pkg::ACC_W-1];
    end
    if (state == ST_ROUND) begin
      acc_q <= 40'((mac_acc + (mac_acc[hhp_pkg::ACC_W-1] ? RND_BIAS : '0))
                   >> hhp_pkg::FRAC_W);
    end
  end

  // Result: trim, clamp, pass-through clamps
  logic signed [40:0] yaw_sum;
  logic signed [40:0] yaw_clamped;
  assign yaw_sum = 41'(acc_q) + 41'(yaw_trim);
  always_comb begin
    if (!flying) begin
      yaw_clamped = '0;
    end else if (yaw_sum > CMAX41) begin
      yaw_clamped = CMAX41;
    end else if (yaw_sum < -CMAX41) begin
      yaw_clamped = -CMAX41;
    end else begin
      yaw_clamped = yaw_sum;
    end
  end

  function automatic logic [14:0] clamp16(input logic signed [15:0] v,
                                          input logic signed [16:0] lim);
    logic signed [16:0] w;
    logic signed [16:0] r;
    begin
      w = 17'(v);
      if (w > lim) begin
        r = lim;
      end else if (w < -lim) begin
        r = -lim;
      end else begin
        r = w;
      end
      return r[14:0];
    end
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= {4'd0, clamp16(thr_sp, CMAX17), clamp16(pitch_sp, CMAX17),
                       clamp16(roll_sp, CMAX17), yaw_clamped[14:0]};
    end
  end

endmodule
`default_nettype wire

// ===== verif/hhp_checker.sv =====
// Result checker for the heading-hold PID loop: follows the register port and
// both stream channels, predicts each command set and compares it with the block.
// Depends on hhp_pkg.
`timescale 1ns / 100ps
module hhp_checker #(
  parameter int CMD_MAX = hhp_pkg::CMD_MAX_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [95:0] s_axis_tdata,
  input  wire         s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [63:0] m_axis_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire         pready,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic signed [14:0] yaw;
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic signed [14:0] throttle;
  } cmd_set_t;

  // Register copies
  logic signed [31:0] prop_gain;
  logic signed [31:0] deriv_gain;
  logic signed [31:0] integ_gain;
  logic signed [14:0] yaw_trim;
  logic        [14:0] heading_step;

  // Loop state
  logic        [15:0] hdg_target;
  logic signed [31:0] err_sum;

  cmd_set_t expected_cmds[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [14:0] got,
                             input logic signed [14:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, $signed(got), want));
  endtask

  function automatic longint clamp_cmd(input longint v);
    if (v > CMD_MAX) return CMD_MAX;
    if (v < -CMD_MAX) return -CMD_MAX;
    return v;
  endfunction

  // One control tick: advance setpoint and integrator, return the command set.
  function automatic cmd_set_t next_commands(input logic flying, input logic [95:0] d);
    logic signed [15:0] hdg;
    logic signed [15:0] rate;
    logic signed [14:0] stick;
    logic signed [15:0] diff;
    longint delta;
    longint err;
    longint sum;
    longint acc;
    longint yaw;
    longint roll;
    longint pitch;
    longint thr;
    cmd_set_t r;
    hdg   = d[15:0];
    rate  = d[31:16];
    stick = d[46:32];
    roll  = clamp_cmd(longint'($signed(d[62:47])));
    pitch = clamp_cmd(longint'($signed(d[78:63])));
    thr   = clamp_cmd(longint'($signed(d[94:79])));
    yaw   = 0;
    if (!flying) begin
      // On the ground: lock the setpoint to the heading, drop the integral
      hdg_target = hdg;
      err_sum = '0;
    end else begin
      // Stick step truncates toward zero; setpoint wraps in 16 bits
      delta = -(longint'(stick) * longint'(heading_step)) / CMD_MAX;
      hdg_target = hdg_target + delta[15:0];
      diff = hdg - hdg_target;
      err = diff;
      sum = longint'(err_sum) + err;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      err_sum = sum[31:0];
      acc = -(longint'(prop_gain) * err + longint'(deriv_gain) * longint'(rate)
              + longint'(integ_gain) * longint'(err_sum));
      yaw = clamp_cmd(acc / (longint'(1) << hhp_pkg::FRAC_W) + longint'(yaw_trim));
    end
    r.yaw      = yaw[14:0];
    r.roll     = roll[14:0];
    r.pitch    = pitch[14:0];
    r.throttle = thr[14:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cmd_set_t want;
    if (rst) begin
      prop_gain    = hhp_pkg::PROP_GAIN_RST;
      deriv_gain   = hhp_pkg::DERIV_GAIN_RST;
      integ_gain   = hhp_pkg::INTEG_GAIN_RST;
      yaw_trim     = hhp_pkg::YAW_TRIM_RST;
      heading_step = hhp_pkg::HDG_STEP_RST;
      hdg_target   = '0;
      err_sum      = '0;
      expected_cmds.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          hhp_pkg::REG_PROP_GAIN:  prop_gain    = pwdata;
          hhp_pkg::REG_DERIV_GAIN: deriv_gain   = pwdata;
          hhp_pkg::REG_INTEG_GAIN: integ_gain   = pwdata;
          hhp_pkg::REG_YAW_TRIM:   yaw_trim     = pwdata[14:0];
          hhp_pkg::REG_HDG_STEP:   heading_step = pwdata[14:0];
          default: ;
        endcase
      end
      // Compare each result transaction with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result %h with no command set pending", m_axis_tdata));
        end else begin
          want = expected_cmds.pop_front();
          check_field("yaw_cmd", m_axis_tdata[14:0], want.yaw);
          check_field("roll_cmd", m_axis_tdata[29:15], want.roll);
          check_field("pitch_cmd", m_axis_tdata[44:30], want.pitch);
          check_field("throttle_cmd", m_axis_tdata[59:45], want.throttle);
        end
      end
      // Predict on each input transaction
      if (s_axis_tvalid && s_axis_tready)
        expected_cmds.push_back(next_commands(s_axis_tuser, s_axis_tdata));
    end
    outstanding <= expected_cmds.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the heading-hold PID loop testbench: clock, reset, register setup,
// stream stimulus and verdict. Depends on hhp_pkg, heading_hold_pid_loop and hhp_checker.
`timescale 1ns / 100ps
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  // [15:0] heading, [31:16] yaw_rate, [46:32] yaw_stick, [62:47] roll_setpoint,
  // [78:63] pitch_setpoint, [94:79] throttle_stick, [95] zero
  logic [95:0] s_axis_tdata = '0;
  // [0] in_flight
  logic        s_axis_tuser = 1'b0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [14:0] yaw_cmd, [29:15] roll_cmd, [44:30] pitch_cmd, [59:45] throttle_cmd, [63:60] zero
  wire  [63:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  int          mismatches;
  int          outstanding;
  logic        steady = 1'b0;   // no idling on either side while set
  logic [15:0] hdg_walk = '0;

  heading_hold_pid_loop uut (.*);
  hhp_checker hhp_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side about one cycle in ten
  always @(posedge clk)
    m_axis_tready <= !rst && (steady || $urandom_range(0, 99) >= 10);

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [31:0] p, input logic [31:0] d,
                               input logic [31:0] i, input logic [31:0] trim,
                               input logic [31:0] step);
    apb_write(hhp_pkg::REG_PROP_GAIN, p);
    apb_write(hhp_pkg::REG_DERIV_GAIN, d);
    apb_write(hhp_pkg::REG_INTEG_GAIN, i);
    apb_write(hhp_pkg::REG_YAW_TRIM, trim);
    apb_write(hhp_pkg::REG_HDG_STEP, step);
  endtask

  task automatic send_item(input logic fly, input logic [15:0] hdg, input logic [15:0] rate,
                           input logic [14:0] stick, input logic [15:0] roll,
                           input logic [15:0] pitch, input logic [15:0] thr);
    // Idle about one cycle in ten before offering the transaction
    while (!steady && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fly;
    s_axis_tdata  <= {1'b0, thr, pitch, roll, stick, rate, hdg};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold the input idle until every command set has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Setpoint-like value: near the clamp edges, inside the range, or anything
  function automatic logic [15:0] passthru_value();
    logic [15:0] near;
    near = 16'(hhp_pkg::CMD_MAX_DEF - 3 + $urandom_range(0, 6));
    case ($urandom_range(0, 3))
      0: return near;
      1: return -near;
      2: return 16'($urandom_range(0, 2 * hhp_pkg::CMD_MAX_DEF) - hhp_pkg::CMD_MAX_DEF);
      default: return 16'($urandom);
    endcase
  endfunction

  // Flights with a drifting heading, broken by touchdowns and heading jumps
  task automatic send_flight_mix(input int count);
    logic        fly;
    logic [14:0] stick;
    for (int k = 0; k < count; k++) begin
      fly = $urandom_range(0, 99) < 90;
      if ($urandom_range(0, 19) == 0) hdg_walk = 16'($urandom);
      else hdg_walk = hdg_walk + 16'($urandom_range(0, 600) - 300);
      stick = ($urandom_range(0, 9) == 0) ? 15'($urandom)
                                           : 15'($urandom_range(0, 19200) - 9600);
      send_item(fly, hdg_walk, 16'($urandom), stick,
                passthru_value(), passthru_value(), passthru_value());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at reset register values
    send_item(1'b0, 16'h7FFF, 16'h0000, 15'd0, 16'h7FFF, 16'h8000, 16'h0000);
    send_item(1'b0, 16'h8000, 16'h7FFF, 15'h3FFF, 16'd9600, -16'sd9600, 16'd9601);
    send_item(1'b1, 16'h8000, 16'h0000, 15'd9600, 16'd0, 16'd0, 16'd0);
    send_item(1'b1, 16'h8000, 16'h0000, -15'sd9600, 16'd1, -16'sd1, 16'd9599);
    // Stick beyond its range, both signs
    send_item(1'b1, 16'h8000, 16'h8000, 15'h3FFF, -16'sd9601, 16'd9599, 16'h8000);
    send_item(1'b1, 16'h7FFF, 16'h7FFF, 15'h4000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    // Heading error across the wrap point
    send_item(1'b1, 16'h0000, 16'hFFFF, 15'd1, 16'h8000, 16'h8000, 16'h8000);
    send_item(1'b1, 16'h8001, 16'h0001, 15'd0, 16'd9600, 16'd9601, -16'sd9601);
    send_item(1'b1, 16'hFFFF, 16'h8000, -15'sd1, 16'd0, 16'd0, 16'd0);
    // Touchdown clears the loop, then zero error gives the trim alone
    send_item(1'b0, 16'h1234, 16'h4321, 15'd9600, 16'd100, 16'd200, 16'd300);
    send_item(1'b1, 16'h1234, 16'h0000, 15'd0, 16'd0, 16'd0, 16'd0);
    // Small sticks around the truncation boundary
    send_item(1'b1, 16'h1234, 16'h0000, -15'sd1, 16'd0, 16'd0, 16'd0);
    send_item(1'b1, 16'h1234, 16'h0000, 15'd23, 16'd0, 16'd0, 16'd0);
    send_item(1'b1, 16'h1234, 16'h0000, 15'd24, 16'd0, 16'd0, 16'd0);
    send_item(1'b1, 16'h1234, 16'h0000, -15'sd24, 16'd0, 16'd0, 16'd0);
    send_item(1'b1, 16'h5555, 16'hAAAA, 15'h2AAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_item(1'b1, 16'hAAAA, 16'h5555, 15'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_flight_mix(270);
    drain();

    // Largest P and I gains, most negative D gain, top trim, full step; junk above the narrow registers
    set_registers(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_3FFF, 32'hA5A5_FFFF);
    send_flight_mix(270);
    drain();

    // Most negative P and I gains, largest D gain, bottom trim, zero step; no idling in this phase
    steady <= 1'b1;
    set_registers(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_4000, 32'h0000_8000);
    send_flight_mix(270);
    drain();
    steady <= 1'b0;

    // Moderate random gains with the trim at its upper command limit
    set_registers(32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000,
                  32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000,
                  32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000,
                  32'd9600, 32'($urandom));
    send_flight_mix(270);
    drain();

    // Anything at all
    set_registers($urandom, $urandom, $urandom, $urandom, $urandom);
    send_flight_mix(190);
    drain();

    // Back to the default gains, trim at its lower limit, unit step
    set_registers(hhp_pkg::PROP_GAIN_RST, hhp_pkg::DERIV_GAIN_RST,
                  hhp_pkg::INTEG_GAIN_RST, -32'sd9600, 32'd1);
    send_flight_mix(80);
    drain();

    repeat (150) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** heading_hold_pid_loop: PASSED **");
    end else begin
      $display("** heading_hold_pid_loop: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("** heading_hold_pid_loop: FAILED **");
    $finish;
  end

endmodule
